FILE: design/mbps_pkg.sv
// Shared constants, codes and types of the masked byte pattern search.
// Used by the channel interfaces, the match cell and the top level.
`timescale 1ns / 1ps

package mbps_pkg;

  // Pattern capacity; the index math below relies on a power of two.
  localparam int PATTERN_MAX = 64;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = 7;
  localparam int MAX_W       = 16;
  localparam int ADDR_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int ENTRY_W     = BYTE_W + 1;
  localparam int OP_W        = 2;
  localparam int EIDX_W      = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES = 1'b1;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift;   // a scan byte enters the window chain
    logic rotate;  // pattern chain moves one cell up
    logic load;    // this cell takes the pattern entry being loaded
    logic active;  // this cell lies inside the pattern length
  } mbps_cell_ctrl_t;

endpackage

FILE: design/mbps_in_if.sv
// Input item channel of the masked byte pattern search.
// Depends on mbps_pkg for field widths.
`timescale 1ns / 1ps

interface mbps_in_if import mbps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [EIDX_W-1:0]   entry_index;
  logic [BYTE_W-1:0]   entry_byte;
  logic                entry_care;
  logic [ADDR_W-1:0]   range_base;
  logic [BYTE_W-1:0]   data_byte;
  logic                last_byte;

  modport source (output valid, op, entry_index, entry_byte, entry_care, range_base,
                  data_byte, last_byte, input ready);
  modport sink   (input valid, op, entry_index, entry_byte, entry_care, range_base,
                  data_byte, last_byte, output ready);
endinterface

FILE: design/mbps_out_if.sv
// Result item channel of the masked byte pattern search.
// Depends on mbps_pkg for field widths.
`timescale 1ns / 1ps

interface mbps_out_if import mbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              match_found;
  logic [ADDR_W-1:0] match_address;
  logic [MAX_W-1:0]  match_total;
  logic              truncated;

  modport source (output valid, match_found, match_address, match_total, truncated,
                  input ready);
  modport sink   (input valid, match_found, match_address, match_total, truncated,
                  output ready);
endinterface

FILE: design/mbps_cell.sv
// One cell of the match chain: a window byte, a pattern entry and a compare.
// Depends on mbps_pkg for widths and the cell control struct.
`timescale 1ns / 1ps

module mbps_cell import mbps_pkg::*; (
  input  logic                 clk,
  input  mbps_cell_ctrl_t      ctrl,
  input  logic [BYTE_W-1:0]    byte_i,
  input  logic [ENTRY_W-1:0]   pat_i,
  input  logic [ENTRY_W-1:0]   load_entry,
  output logic [BYTE_W-1:0]    byte_o,
  output logic [ENTRY_W-1:0]   pat_o,
  output logic                 match_o
);

  logic [BYTE_W-1:0]  win_r, win_nxt;
  logic [ENTRY_W-1:0] pat_r, pat_nxt;

  // Window byte moves one cell per scan byte.
  always_comb begin
    win_nxt = ctrl.shift ? byte_i : win_r;
  end

  // Pattern entry is loaded in place or rotated from the neighbor below.
  always_comb begin
    pat_nxt = pat_r;
    if (ctrl.load) begin
      pat_nxt = load_entry;
    end else if (ctrl.rotate) begin
      pat_nxt = pat_i;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    pat_r <= pat_nxt;
  end

  // The compare looks at the window as it stands after this byte.
  assign match_o = !ctrl.active || !pat_r[BYTE_W] || (pat_r[BYTE_W-1:0] == win_nxt);
  assign byte_o  = win_r;
  assign pat_o   = pat_r;

endmodule

FILE: design/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search: control, counters and the cell chain.
// Depends on mbps_pkg, mbps_in_if, mbps_out_if and mbps_cell.
`timescale 1ns / 1ps

// Usage:
// Items arrive on in_ch (valid/ready); each one yields exactly one result on
// out_ch. A load item writes one pattern entry, a begin item opens a range at
// range_base, and each scan byte reports whether a match ends at it, with the
// start address of that match.
// The result of an item is registered and valid in the cycle after it is accepted.
// Throughput is one item per cycle while the pattern chain is aligned and the
// receiver takes results, set by the cell chain that shifts the window and
// compares all pattern positions in the same cycle. Writing the length register
// rotates the pattern chain one cell per cycle until it lines up with the new
// length, with in_ch ready low in that time. Configuration writes on cfg_we are
// always taken. When the receiver stalls, the result stays in the output register
// and the input takes a new item only in a cycle in which that result is taken.
// Reset (rst_n low, synchronous) closes the range, clears the counters and
// sets both registers to 1. Pattern entries hold garbage until loaded.

module masked_byte_pattern_search import mbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mbps_in_if.sink               in_ch,
  mbps_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [LEN_W-1:0] pat_len_r;
  logic [MAX_W-1:0] max_matches_r;

  // Range state.
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [MAX_W-1:0]  cnt_r, cnt_nxt;
  logic              limit_hit_r, limit_hit_nxt;
  logic              closed_r, closed_nxt;

  // Pattern chain alignment.
  logic [IDX_W-1:0]  rot_cur_r;
  logic [IDX_W-1:0]  rot_tgt;
  logic              busy;

  // Output register.
  logic              out_valid_r;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] maddr_r, maddr_nxt;

  logic              accept;
  logic              scan_open;
  logic              window_hit;
  logic [LEN_W-1:0]  len_eff;
  logic [MAX_W-1:0]  limit_eff;
  logic [IDX_W-1:0]  load_pos;
  logic              load_ok;

  mbps_cell_ctrl_t   cell_ctrl [PATTERN_MAX];
  logic [BYTE_W-1:0] cell_byte [PATTERN_MAX];
  logic [ENTRY_W-1:0] cell_pat [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_match;
  logic [ENTRY_W-1:0] load_entry;

  // Effective length and limit after clamping.
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = pat_len_r;
    end
    limit_eff = (max_matches_r == '0) ? MAX_W'(1) : max_matches_r;
  end

  // Pattern entry j sits in cell (len-1-j) mod PATTERN_MAX.
  assign rot_tgt = IDX_W'(len_eff - LEN_W'(1));
  assign busy    = rot_cur_r != rot_tgt;

  assign in_ch.ready = !busy && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign scan_open   = accept && (in_ch.op == OP_SCAN) && !closed_r;

  assign load_pos   = rot_cur_r - IDX_W'(in_ch.entry_index);
  assign load_ok    = accept && (in_ch.op == OP_LOAD) &&
                      ({1'b0, in_ch.entry_index} < (EIDX_W + 1)'(PATTERN_MAX));
  assign load_entry = {in_ch.entry_care, in_ch.entry_byte};

  // Control of each cell.
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      cell_ctrl[k].shift  = scan_open;
      cell_ctrl[k].rotate = busy;
      cell_ctrl[k].load   = load_ok && (load_pos == IDX_W'(k));
      cell_ctrl[k].active = LEN_W'(k) < len_eff;
    end
  end

  // The chain: window bytes move up from cell 0, pattern entries rotate up.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    mbps_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[k]),
      .byte_i     ((k == 0) ? in_ch.data_byte : cell_byte[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
      .pat_i      (cell_pat[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
      .load_entry (load_entry),
      .byte_o     (cell_byte[k]),
      .pat_o      (cell_pat[k]),
      .match_o    (cell_match[k])
    );
  end

  // Saturating count of bytes seen, enough to know the window is full.
  assign fill_nxt   = (fill_r == LEN_W'(PATTERN_MAX)) ? fill_r : fill_r + LEN_W'(1);
  assign window_hit = scan_open && (&cell_match) && (fill_nxt >= len_eff);

  // Next range state and result.
  always_comb begin
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    limit_hit_nxt = limit_hit_r;
    closed_nxt    = closed_r;
    found_nxt     = 1'b0;
    maddr_nxt     = '0;
    if (accept && (in_ch.op == OP_BEGIN)) begin
      addr_nxt      = in_ch.range_base;
      cnt_nxt       = '0;
      limit_hit_nxt = 1'b0;
      closed_nxt    = 1'b0;
    end else if (scan_open) begin
      addr_nxt = addr_r + ADDR_W'(1);
      if (window_hit) begin
        if (cnt_r < limit_eff) begin
          cnt_nxt   = cnt_r + MAX_W'(1);
          found_nxt = 1'b1;
          maddr_nxt = addr_r - ADDR_W'(len_eff - LEN_W'(1));
        end else begin
          limit_hit_nxt = 1'b1;
        end
      end
      if (in_ch.last_byte) begin
        closed_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r     <= LEN_W'(1);
      max_matches_r <= MAX_W'(1);
      rot_cur_r     <= '0;
      fill_r        <= '0;
      cnt_r         <= '0;
      limit_hit_r   <= 1'b0;
      closed_r      <= 1'b1;
      addr_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAT_LEN:     pat_len_r     <= cfg_data[LEN_W-1:0];
          CFG_MAX_MATCHES: max_matches_r <= cfg_data[MAX_W-1:0];
          default: ;
        endcase
      end
      if (busy) begin
        rot_cur_r <= rot_cur_r + IDX_W'(1);
      end
      if (accept && (in_ch.op == OP_BEGIN)) begin
        fill_r <= '0;
      end else if (scan_open) begin
        fill_r <= fill_nxt;
      end
      cnt_r       <= cnt_nxt;
      limit_hit_r <= limit_hit_nxt;
      closed_r    <= closed_nxt;
      addr_r      <= addr_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      found_r <= found_nxt;
      maddr_r <= maddr_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.match_found   = found_r;
  assign out_ch.match_address = maddr_r;
  assign out_ch.match_total   = cnt_r;
  assign out_ch.truncated     = limit_hit_r;

`ifndef NO_ASSERTIONS
  // No item is taken while the pattern chain is still being realigned.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("item accepted during pattern rotation");

  // Every accepted item leaves a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("accepted item produced no result");

  // A reported match always raises the match count.
  a_found_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && found_nxt) |=> (cnt_r == $past(cnt_r) + MAX_W'(1)))
    else $error("reported match not counted");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for masked_byte_pattern_search: valid/ready items in and out.
// A built-in predictor computes each expected result; depends on mbps_pkg and the channel
// interfaces of the design.
`timescale 1ns / 1ps

module tb_top;
  import mbps_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 580;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [EIDX_W-1:0] entry_index;
    logic [BYTE_W-1:0] entry_byte;
    logic              entry_care;
    logic [ADDR_W-1:0] range_base;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } search_item_t;

  typedef struct {
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
    logic [MAX_W-1:0]  match_total;
    logic              truncated;
  } match_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbps_in_if  in_ch();
  mbps_out_if out_ch();

  masked_byte_pattern_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: pattern, byte window, range counters and registers.
  logic [ENTRY_W-1:0] pat_mem [PATTERN_MAX];
  logic [BYTE_W-1:0]  win [PATTERN_MAX];
  logic [ADDR_W-1:0]  base_q;
  logic [63:0]        seen_q;
  logic [MAX_W-1:0]   hits_q;
  logic               over_q;
  logic               closed_q;
  logic [LEN_W-1:0]   len_reg;
  logic [MAX_W-1:0]   max_reg;

  match_report_t search_reports_due[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;
  int mismatch_count;
  int results_checked;
  int matches_checked;
  int useful_items;
  int ranges_run;
  int truncations;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pattern length as the block uses it.
  function automatic int effective_length(int len);
    if (len == 0) return 1;
    if (len > PATTERN_MAX) return PATTERN_MAX;
    return len;
  endfunction

  // The oldest byte of the window lines up with pattern position 0.
  function automatic bit window_holds_pattern(int len);
    for (int j = 0; j < len; j++) begin
      if (pat_mem[j][BYTE_W] && pat_mem[j][BYTE_W-1:0] != win[len-1-j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one accepted item to the predictor state and returns its result.
  function automatic match_report_t predict_search_step(search_item_t it);
    match_report_t rep;
    int len_used;
    int limit_used;
    rep.match_found   = 1'b0;
    rep.match_address = '0;
    case (it.op)
      OP_LOAD: begin
        pat_mem[it.entry_index] = {it.entry_care, it.entry_byte};
        useful_items++;
      end
      OP_BEGIN: begin
        base_q   = it.range_base;
        seen_q   = '0;
        hits_q   = '0;
        over_q   = 1'b0;
        closed_q = 1'b0;
        foreach (win[k]) win[k] = '0;
        useful_items++;
      end
      OP_SCAN: begin
        if (!closed_q) begin
          useful_items++;
          len_used   = effective_length(int'(len_reg));
          limit_used = (max_reg == 0) ? 1 : int'(max_reg);
          for (int k = PATTERN_MAX - 1; k > 0; k--) win[k] = win[k-1];
          win[0] = it.data_byte;
          seen_q = seen_q + 64'd1;
          if (seen_q >= 64'(len_used) && window_holds_pattern(len_used)) begin
            if (int'(hits_q) < limit_used) begin
              hits_q            = hits_q + 16'd1;
              rep.match_found   = 1'b1;
              rep.match_address = base_q + (seen_q - 64'(len_used));
            end else begin
              if (!over_q) truncations++;
              over_q = 1'b1;
            end
          end
          if (it.last_byte) closed_q = 1'b1;
        end
      end
      default: ;
    endcase
    rep.match_total = hits_q;
    rep.truncated   = over_q;
    return rep;
  endfunction

  // Item builders; fields that the operation does not use carry random values.
  function automatic search_item_t junk_item();
    search_item_t it;
    it.op          = OP_UNUSED;
    it.entry_index = EIDX_W'($urandom);
    it.entry_byte  = BYTE_W'($urandom);
    it.entry_care  = 1'($urandom);
    it.range_base  = {$urandom, $urandom};
    it.data_byte   = BYTE_W'($urandom);
    it.last_byte   = 1'($urandom);
    return it;
  endfunction

  function automatic search_item_t load_item(int idx, logic [BYTE_W-1:0] b, logic care);
    search_item_t it;
    it             = junk_item();
    it.op          = OP_LOAD;
    it.entry_index = EIDX_W'(idx);
    it.entry_byte  = b;
    it.entry_care  = care;
    return it;
  endfunction

  function automatic search_item_t begin_item(logic [ADDR_W-1:0] base);
    search_item_t it;
    it            = junk_item();
    it.op         = OP_BEGIN;
    it.range_base = base;
    return it;
  endfunction

  function automatic search_item_t scan_item(logic [BYTE_W-1:0] b, logic last);
    search_item_t it;
    it           = junk_item();
    it.op        = OP_SCAN;
    it.data_byte = b;
    it.last_byte = last;
    return it;
  endfunction

  // Offers one item, with random idle cycles first, and waits until it is accepted.
  task automatic send_item(input search_item_t it);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= it.op;
    in_ch.entry_index <= it.entry_index;
    in_ch.entry_byte  <= it.entry_byte;
    in_ch.entry_care  <= it.entry_care;
    in_ch.range_base  <= it.range_base;
    in_ch.data_byte   <= it.data_byte;
    in_ch.last_byte   <= it.last_byte;
    do @(posedge clk); while (!in_ch.ready);
    search_reports_due.push_back(predict_search_step(it));
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (search_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on back-to-back cycles; the block must be idle.
  task automatic write_settings(int len, int max_hits);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAT_LEN;
    cfg_data  <= CFG_DATA_W'(len);
    @(posedge clk);
    len_reg    = LEN_W'(len);
    cfg_index <= CFG_MAX_MATCHES;
    cfg_data  <= CFG_DATA_W'(max_hits);
    @(posedge clk);
    max_reg = MAX_W'(max_hits);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("ERROR: result %0d: %s is 0x%0h, expected 0x%0h", results_checked, what, got,
               want);
  endtask

  // Compares one accepted result with the oldest expected one.
  task automatic check_result();
    match_report_t want;
    if (search_reports_due.size() == 0) begin
      report_mismatch("result with nothing expected", 64'(out_ch.match_total), 64'(0));
      return;
    end
    want = search_reports_due.pop_front();
    results_checked++;
    if (out_ch.match_found !== want.match_found)
      report_mismatch("match_found", 64'(out_ch.match_found), 64'(want.match_found));
    if (out_ch.match_address !== want.match_address)
      report_mismatch("match_address", out_ch.match_address, want.match_address);
    if (out_ch.match_total !== want.match_total)
      report_mismatch("match_total", 64'(out_ch.match_total), 64'(want.match_total));
    if (out_ch.truncated !== want.truncated)
      report_mismatch("truncated", 64'(out_ch.truncated), 64'(want.truncated));
    if (want.match_found) matches_checked++;
  endtask

  // Result receiver: checks each accepted result, then picks ready for the next cycle.
  // A hold request keeps ready low until the requested hold has run out.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result();
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
    $display("masked_byte_pattern_search: mismatch");
    $finish;
  end

  // Scan bytes before any range is opened are ignored, as is an unused opcode.
  task automatic test_closed_scan();
    send_item(scan_item(8'h00, 1'b0));
    send_item(scan_item(8'hFF, 1'b1));
    send_item(junk_item());
  endtask

  // Writes every pattern entry so that later scans never read an unloaded one.
  task automatic test_load_all_entries();
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (j == 0)
        send_item(load_item(j, 8'h00, 1'b1));
      else if (j == 1)
        send_item(load_item(j, 8'hFF, 1'b0));
      else
        send_item(load_item(j, BYTE_W'($urandom), 1'($urandom)));
    end
  endtask

  // A zero limit acts as one: the second match is dropped and sets truncated.
  // Bytes after the last one are ignored.
  task automatic test_match_limit();
    drain_results();
    write_settings(3, 0);
    send_item(load_item(0, 8'hAA, 1'b1));
    send_item(load_item(1, 8'h5A, 1'b0));
    send_item(load_item(2, 8'h55, 1'b1));
    send_item(begin_item(64'hFFFF_FFFF_FFFF_FFFE));
    send_item(scan_item(8'h00, 1'b0));
    send_item(scan_item(8'hAA, 1'b0));
    send_item(scan_item(8'h77, 1'b0));
    send_item(scan_item(8'h55, 1'b0));
    send_item(scan_item(8'hAA, 1'b0));
    send_item(scan_item(8'h00, 1'b0));
    send_item(scan_item(8'h55, 1'b1));
    send_item(scan_item(8'hAA, 1'b0));
    send_item(junk_item());
  endtask

  // Length zero acts as one, with match addresses wrapping past the top; a length
  // above the capacity acts as the capacity, so a short range reports nothing.
  task automatic test_length_clamp();
    drain_results();
    write_settings(0, 16'hFFFF);
    send_item(load_item(0, 8'h3C, 1'b1));
    send_item(begin_item(64'hFFFF_FFFF_FFFF_FFFF));
    send_item(scan_item(8'h3C, 1'b0));
    send_item(scan_item(8'h3C, 1'b0));
    send_item(scan_item(8'h00, 1'b0));
    send_item(scan_item(8'h3C, 1'b1));
    drain_results();
    write_settings(127, 16'hFFFF);
    send_item(begin_item(64'h0));
    repeat (3) send_item(scan_item(BYTE_W'($urandom), 1'b0));
    send_item(scan_item(8'h00, 1'b1));
  endtask

  // The receiver stops for a long stretch while scan bytes keep coming, so the
  // block fills up and holds off its input.
  task automatic test_output_stall();
    int saved_tx;
    saved_tx = tx_idle_pct;
    drain_results();
    write_settings(2, 16'hFFFF);
    send_item(load_item(0, 8'h41, 1'b1));
    send_item(load_item(1, 8'h42, 1'b0));
    send_item(begin_item({$urandom, $urandom}));
    tx_idle_pct = 0;
    rx_hold_req = 300;
    for (int k = 0; k < 40; k++)
      send_item(scan_item((k % 3 == 0) ? 8'h41 : BYTE_W'($urandom), k == 39));
    tx_idle_pct = saved_tx;
  endtask

  // One random range: settings, a fresh pattern, a begin and a scan stream in which
  // copies of the pattern are planted, with some noise and broken sequences.
  task automatic run_random_range();
    int pick;
    int len_cfg;
    int max_cfg;
    int eff;
    int nscan;
    int sent;
    int prefix;
    logic [ADDR_W-1:0] base;
    logic [BYTE_W-1:0] planned[$];

    pick = $urandom_range(99);
    if (pick < 4) len_cfg = 0;
    else if (pick < 10) len_cfg = PATTERN_MAX;
    else if (pick < 13) len_cfg = $urandom_range(PATTERN_MAX + 1, 127);
    else if (pick < 30) len_cfg = $urandom_range(9, 24);
    else len_cfg = $urandom_range(1, 8);
    eff = effective_length(len_cfg);

    pick = $urandom_range(99);
    if (pick < 10) max_cfg = 0;
    else if (pick < 25) max_cfg = 1;
    else if (pick < 45) max_cfg = $urandom_range(2, 4);
    else if (pick < 55) max_cfg = 16'hFFFF;
    else if (pick < 70) max_cfg = $urandom_range(0, 16'hFFFF);
    else max_cfg = $urandom_range(5, 40);

    pick = $urandom_range(99);
    if (pick < 15) base = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(255));
    else if (pick < 25) base = '0;
    else base = {$urandom, $urandom};

    if ($urandom_range(99) < 10) nscan = $urandom_range(1, eff);
    else nscan = eff + $urandom_range(0, (eff < 16) ? 36 : eff + 20);

    drain_results();
    write_settings(len_cfg, max_cfg);
    for (int j = 0; j < eff; j++)
      send_item(load_item(j, BYTE_W'($urandom), $urandom_range(99) < 75));
    send_item(begin_item(base));
    ranges_run++;

    sent = 0;
    while (sent < nscan) begin
      // Refill the planned stream with a full copy, a broken prefix or a stray byte.
      if (planned.size() == 0) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          for (int j = 0; j < eff; j++)
            planned.push_back(pat_mem[j][BYTE_W] ? pat_mem[j][BYTE_W-1:0] : BYTE_W'($urandom));
        end else if (pick < 60) begin
          prefix = $urandom_range(0, eff - 1);
          for (int j = 0; j < prefix; j++) planned.push_back(pat_mem[j][BYTE_W-1:0]);
          planned.push_back(BYTE_W'($urandom));
        end else if (pick < 80) begin
          planned.push_back(pat_mem[$urandom_range(0, eff - 1)][BYTE_W-1:0]);
        end else begin
          planned.push_back(BYTE_W'($urandom));
        end
      end
      // Occasional noise: unused opcode, pattern rewrite or a range restart.
      pick = $urandom_range(99);
      if (pick < 3) send_item(junk_item());
      else if (pick < 5) send_item(load_item($urandom_range(0, PATTERN_MAX - 1),
                                             BYTE_W'($urandom), 1'($urandom)));
      else if (pick < 6) send_item(begin_item({$urandom, $urandom}));
      send_item(scan_item(planned.pop_front(), sent == nscan - 1));
      sent++;
    end

    // Bytes past the end of the range.
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 3)) send_item(scan_item(BYTE_W'($urandom), 1'($urandom)));
  endtask

  task automatic run_random_phase(int tx_pct, int rx_pct, int goal);
    drain_results();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (useful_items < goal) run_random_range();
  endtask

  // Main sequence.
  initial begin : stimulus
    int start_items;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_LOAD;
    in_ch.entry_index <= '0;
    in_ch.entry_byte  <= '0;
    in_ch.entry_care  <= 1'b0;
    in_ch.range_base  <= '0;
    in_ch.data_byte   <= '0;
    in_ch.last_byte   <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_PAT_LEN;
    cfg_data          <= '0;
    rst_n             <= 1'b0;

    foreach (pat_mem[k]) pat_mem[k] = '0;
    foreach (win[k]) win[k] = '0;
    base_q          = '0;
    seen_q          = '0;
    hits_q          = '0;
    over_q          = 1'b0;
    closed_q        = 1'b1;
    len_reg         = LEN_W'(1);
    max_reg         = MAX_W'(1);
    tx_idle_pct     = 20;
    rx_idle_pct     = 73;
    rx_hold_req     = 0;
    mismatch_count  = 0;
    results_checked = 0;
    matches_checked = 0;
    useful_items    = 0;
    ranges_run      = 0;
    truncations     = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_closed_scan();
    test_load_all_entries();
    test_match_limit();
    test_length_clamp();
    test_output_stall();

    start_items = useful_items;
    run_random_phase(20, 73, start_items + PHASE_ITEMS);
    run_random_phase(73, 20, start_items + 2 * PHASE_ITEMS);
    run_random_phase(0, 0, start_items + 3 * PHASE_ITEMS);

    drain_results();
    $display("Checked %0d results over %0d random ranges and the directed cases,",
             results_checked, ranges_run);
    $display("with %0d matches reported and %0d ranges cut off by the limit.",
             matches_checked, truncations);
    if (mismatch_count == 0)
      $display("masked_byte_pattern_search: match");
    else
      $display("masked_byte_pattern_search: mismatch");
    $finish;
  end

endmodule
